@@ rtl/core/gwmc_pkg.sv @@
// ----------------------------------------------------------------------------
// gwmc_pkg: shared types and constants for the grid window minimum cost block
// Sizes of the grid and window stores, cell codes, register indexes and the
// item that travels from the front stage to the back stage.
// ----------------------------------------------------------------------------
package gwmc_pkg;

	// grid and window limits
	localparam int MAX_WIDTH   = 256;
	localparam int MAX_WINDOW  = 256;
	localparam int COL_W       = $clog2(MAX_WIDTH);
	localparam int SLOT_W      = $clog2(MAX_WINDOW);
	localparam int LINE_AW     = SLOT_W + COL_W;
	localparam int LINE_DEPTH  = MAX_WINDOW * MAX_WIDTH;

	// counts and configuration
	localparam int CNT_W       = 9;
	localparam int CFG_W       = 9;
	localparam int CFG_IDX_W   = 1;

	// decoupling queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	// sized constants
	localparam logic [CNT_W-1:0]  CNT_ONE          = CNT_W'(1);
	localparam logic [CNT_W-1:0]  CNT_MAX_WIDTH    = CNT_W'(MAX_WIDTH);
	localparam logic [CNT_W-1:0]  CNT_MAX_WINDOW   = CNT_W'(MAX_WINDOW);
	localparam logic [CFG_W-1:0]  ROW_LENGTH_RESET = CFG_W'(256);
	localparam logic [CFG_W-1:0]  WINDOW_LEN_RESET = CFG_W'(1);
	localparam logic [QCNT_W-1:0] QCNT_FULL        = QCNT_W'(QUEUE_DEPTH);
	localparam logic [COL_W-1:0]  COL_ONE          = COL_W'(1);
	localparam logic [SLOT_W-1:0] SLOT_ONE         = SLOT_W'(1);
	localparam logic [QPTR_W-1:0] QPTR_ONE         = QPTR_W'(1);
	localparam logic [QCNT_W-1:0] QCNT_ONE         = QCNT_W'(1);

	// cell codes
	localparam logic [1:0] KIND_COST    = 2'd1;
	localparam logic [1:0] KIND_BLOCKED = 2'd2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_LENGTH = 1'b0,
		REG_WINDOW_LEN = 1'b1
	} cfg_reg_t;

	// classified cell handed from front to back
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             active;
		logic             is_cost;
		logic             is_block;
		logic             row_sub_cost;
		logic             row_sub_block;
		logic             col_sub_cost;
		logic             col_sub_block;
		logic             row_offer;
		logic             col_offer;
		logic             row_end;
		logic             last;
	} item_t;

	// cost and blocked counts of one run
	typedef struct packed {
		logic [CNT_W-1:0] cost;
		logic [CNT_W-1:0] block;
	} count_pair_t;

	// queue status seen by the front
	typedef struct packed {
		logic [QCNT_W-1:0] count;
	} queue_status_t;

	// running count update, wraps at the count width
	function automatic logic [CNT_W-1:0] step_count(input logic [CNT_W-1:0] v,
		input logic add, input logic sub);
		logic [CNT_W-1:0] add_ext;
		logic [CNT_W-1:0] sub_ext;
		add_ext = {{(CNT_W-1){1'b0}}, add};
		sub_ext = {{(CNT_W-1){1'b0}}, sub};
		return v + add_ext - sub_ext;
	endfunction

endpackage

@@ rtl/core/gwmc_front.sv @@
// ----------------------------------------------------------------------------
// gwmc_front: cell intake and classification
// Holds the configuration, walks the raster position, keeps the row history
// and the line store, and hands each classified cell to the queue.
// ----------------------------------------------------------------------------
module gwmc_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      cell_kind,
	input  logic                            last_cell,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic                            cfg_we,
	input  logic [gwmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gwmc_pkg::CFG_W-1:0]      cfg_data,
	input  gwmc_pkg::queue_status_t         q_status,
	output logic                            push,
	output gwmc_pkg::item_t                 push_item
);

	// configuration registers
	logic [gwmc_pkg::CFG_W-1:0]  row_length_q;
	logic [gwmc_pkg::CFG_W-1:0]  window_len_q;

	// raster position
	logic [gwmc_pkg::COL_W-1:0]  col_q;
	logic [gwmc_pkg::CNT_W-1:0]  rows_q;
	logic [gwmc_pkg::SLOT_W-1:0] slot_q;

	// stores
	logic [1:0] hist_mem [gwmc_pkg::MAX_WIDTH];
	logic [1:0] line_mem [gwmc_pkg::LINE_DEPTH];

	// stage one
	logic                        s1_v;
	gwmc_pkg::item_t             item_s1;
	logic                        row_sub_s1;
	logic                        col_sub_s1;
	logic [1:0]                  hist_rd_s1;
	logic [1:0]                  line_rd_s1;

	// decode
	logic [gwmc_pkg::CNT_W-1:0]   rl_eff;
	logic [gwmc_pkg::CNT_W-1:0]   w_eff;
	logic [gwmc_pkg::CNT_W-1:0]   col_ext;
	logic [gwmc_pkg::CNT_W-1:0]   col_next;
	logic [gwmc_pkg::QCNT_W-1:0]  fill;
	logic                         active;
	logic                         row_sub;
	logic                         row_offer;
	logic                         col_sub;
	logic                         col_offer;
	logic                         row_end;
	logic                         accept;
	logic [gwmc_pkg::COL_W-1:0]   hist_raddr;
	logic [gwmc_pkg::LINE_AW-1:0] line_raddr;
	logic [gwmc_pkg::LINE_AW-1:0] line_waddr;

	// clamp configuration and classify the position
	always_comb begin
		if (row_length_q == '0) begin
			rl_eff = gwmc_pkg::CNT_ONE;
		end else if (row_length_q > gwmc_pkg::CNT_MAX_WIDTH) begin
			rl_eff = gwmc_pkg::CNT_MAX_WIDTH;
		end else begin
			rl_eff = row_length_q;
		end
		w_eff = (window_len_q == '0) ? gwmc_pkg::CNT_ONE : window_len_q;
		active = w_eff <= gwmc_pkg::CNT_MAX_WINDOW;
		col_ext = {{(gwmc_pkg::CNT_W-gwmc_pkg::COL_W){1'b0}}, col_q};
		col_next = col_ext + gwmc_pkg::CNT_ONE;
		row_sub = col_ext >= w_eff;
		row_offer = col_next >= w_eff;
		col_sub = rows_q >= w_eff;
		col_offer = (rows_q + gwmc_pkg::CNT_ONE) >= w_eff;
		row_end = col_next >= rl_eff;
		hist_raddr = col_q - w_eff[gwmc_pkg::COL_W-1:0];
		line_raddr = {slot_q - w_eff[gwmc_pkg::SLOT_W-1:0], col_q};
		line_waddr = {slot_q, col_q};
	end

	// accept only when the queue keeps room for the item in stage one
	assign fill = q_status.count + {{(gwmc_pkg::QCNT_W-1){1'b0}}, s1_v};
	assign in_stall = fill >= gwmc_pkg::QCNT_FULL;
	assign accept = in_valid && !in_stall;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= gwmc_pkg::ROW_LENGTH_RESET;
			window_len_q <= gwmc_pkg::WINDOW_LEN_RESET;
		end else if (cfg_we) begin
			case (gwmc_pkg::cfg_reg_t'(cfg_index))
				gwmc_pkg::REG_ROW_LENGTH: row_length_q <= cfg_data;
				gwmc_pkg::REG_WINDOW_LEN: window_len_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// raster position and stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			rows_q <= '0;
			slot_q <= '0;
			s1_v <= 1'b0;
		end else begin
			s1_v <= accept;
			if (accept) begin
				if (last_cell) begin
					col_q <= '0;
					rows_q <= '0;
					slot_q <= '0;
				end else if (row_end) begin
					col_q <= '0;
					slot_q <= slot_q + gwmc_pkg::SLOT_ONE;
					if (rows_q < gwmc_pkg::CNT_MAX_WINDOW) begin
						rows_q <= rows_q + gwmc_pkg::CNT_ONE;
					end
				end else begin
					col_q <= col_q + gwmc_pkg::COL_ONE;
				end
			end
		end
	end

	// history stores and stage one payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (active) begin
				hist_mem[col_q] <= cell_kind;
				line_mem[line_waddr] <= cell_kind;
			end
			hist_rd_s1 <= hist_mem[hist_raddr];
			line_rd_s1 <= line_mem[line_raddr];
			item_s1.col <= col_q;
			item_s1.active <= active;
			item_s1.is_cost <= cell_kind == gwmc_pkg::KIND_COST;
			item_s1.is_block <= cell_kind == gwmc_pkg::KIND_BLOCKED;
			item_s1.row_sub_cost <= 1'b0;
			item_s1.row_sub_block <= 1'b0;
			item_s1.col_sub_cost <= 1'b0;
			item_s1.col_sub_block <= 1'b0;
			item_s1.row_offer <= row_offer;
			item_s1.col_offer <= col_offer;
			item_s1.row_end <= row_end;
			item_s1.last <= last_cell;
			row_sub_s1 <= row_sub;
			col_sub_s1 <= col_sub;
		end
	end

	// attach the cells that leave the runs
	always_comb begin
		push_item = item_s1;
		push_item.row_sub_cost = row_sub_s1 && (hist_rd_s1 == gwmc_pkg::KIND_COST);
		push_item.row_sub_block = row_sub_s1 && (hist_rd_s1 == gwmc_pkg::KIND_BLOCKED);
		push_item.col_sub_cost = col_sub_s1 && (line_rd_s1 == gwmc_pkg::KIND_COST);
		push_item.col_sub_block = col_sub_s1 && (line_rd_s1 == gwmc_pkg::KIND_BLOCKED);
	end

	assign push = s1_v;

endmodule

@@ rtl/core/gwmc_queue.sv @@
// ----------------------------------------------------------------------------
// gwmc_queue: short queue between front and back
// Circular buffer of classified cells so that each side can stall on its own.
// ----------------------------------------------------------------------------
module gwmc_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  gwmc_pkg::item_t         push_item,
	input  logic                    pop,
	output gwmc_pkg::item_t         head,
	output logic                    head_valid,
	output gwmc_pkg::queue_status_t status
);

	gwmc_pkg::item_t               entry_q [gwmc_pkg::QUEUE_DEPTH];
	logic [gwmc_pkg::QPTR_W-1:0]   wr_ptr_q;
	logic [gwmc_pkg::QPTR_W-1:0]   rd_ptr_q;
	logic [gwmc_pkg::QCNT_W-1:0]   count_q;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + gwmc_pkg::QPTR_ONE;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + gwmc_pkg::QPTR_ONE;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + gwmc_pkg::QCNT_ONE;
				2'b01: count_q <= count_q - gwmc_pkg::QCNT_ONE;
				default: ;
			endcase
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	assign head = entry_q[rd_ptr_q];
	assign head_valid = count_q != '0;
	assign status.count = count_q;

endmodule

@@ rtl/core/gwmc_back.sv @@
// ----------------------------------------------------------------------------
// gwmc_back: run counts and minimum tracking
// Updates the row counts and the per-column counts, offers every complete
// run to the minimum and emits the result on the last cell of a grid.
// ----------------------------------------------------------------------------
module gwmc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  gwmc_pkg::item_t              head,
	input  logic                         head_valid,
	output logic                         pop,
	output logic [gwmc_pkg::CNT_W-1:0]   min_cost,
	output logic                         found,
	output logic                         out_valid,
	input  logic                         out_stall
);

	// stage two
	logic                           v_s2;
	gwmc_pkg::item_t                item_s2;
	gwmc_pkg::count_pair_t          col_rd_s2;
	logic                           col_vld_s2;
	logic                           fwd_en_s2;
	gwmc_pkg::count_pair_t          fwd_val_s2;

	// column counts with per-entry valid bits
	gwmc_pkg::count_pair_t          col_mem [gwmc_pkg::MAX_WIDTH];
	logic [gwmc_pkg::MAX_WIDTH-1:0] col_vld_q;

	// row counts and best run
	gwmc_pkg::count_pair_t          row_q;
	logic [gwmc_pkg::CNT_W-1:0]     best_q;
	logic                           best_v_q;

	// result register
	logic                           out_valid_q;
	logic [gwmc_pkg::CNT_W-1:0]     min_cost_q;
	logic                           found_q;

	// datapath
	logic                           adv;
	logic                           col_write;
	gwmc_pkg::count_pair_t          col_old;
	gwmc_pkg::count_pair_t          col_new;
	gwmc_pkg::count_pair_t          row_new;
	logic                           row_ok;
	logic                           col_ok;
	logic [gwmc_pkg::CNT_W-1:0]     best_next;
	logic                           best_v_next;
	logic                           fwd_en_next;
	gwmc_pkg::count_pair_t          fwd_val_next;

	// stage two moves on unless a result waits and the cell is a last one
	assign adv = v_s2 && (!item_s2.last || !out_valid_q || !out_stall);
	assign pop = head_valid && (!v_s2 || adv);
	assign col_write = adv && item_s2.active;

	// count updates and offers
	always_comb begin
		if (fwd_en_s2) begin
			col_old = fwd_val_s2;
		end else if (col_vld_s2) begin
			col_old = col_rd_s2;
		end else begin
			col_old = '0;
		end
		col_new.cost = gwmc_pkg::step_count(col_old.cost, item_s2.is_cost,
			item_s2.col_sub_cost);
		col_new.block = gwmc_pkg::step_count(col_old.block, item_s2.is_block,
			item_s2.col_sub_block);
		row_new.cost = gwmc_pkg::step_count(row_q.cost, item_s2.is_cost,
			item_s2.row_sub_cost);
		row_new.block = gwmc_pkg::step_count(row_q.block, item_s2.is_block,
			item_s2.row_sub_block);
		row_ok = item_s2.active && item_s2.row_offer && (row_new.block == '0);
		col_ok = item_s2.active && item_s2.col_offer && (col_new.block == '0);

		best_next = best_q;
		best_v_next = best_v_q;
		if (row_ok && (!best_v_next || (row_new.cost < best_next))) begin
			best_next = row_new.cost;
			best_v_next = 1'b1;
		end
		if (col_ok && (!best_v_next || (col_new.cost < best_next))) begin
			best_next = col_new.cost;
			best_v_next = 1'b1;
		end
	end

	// forward a same-edge write or a grid clear to the next column read
	always_comb begin
		fwd_en_next = 1'b0;
		fwd_val_next = '0;
		if (adv && item_s2.last) begin
			fwd_en_next = 1'b1;
		end else if (col_write && (item_s2.col == head.col)) begin
			fwd_en_next = 1'b1;
			fwd_val_next = col_new;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			fwd_en_s2 <= 1'b0;
			col_vld_q <= '0;
			row_q <= '0;
			best_q <= '0;
			best_v_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			v_s2 <= pop || (v_s2 && !adv);
			if (pop) begin
				fwd_en_s2 <= fwd_en_next;
			end
			if (adv && item_s2.last) begin
				col_vld_q <= '0;
			end else if (col_write) begin
				col_vld_q[item_s2.col] <= 1'b1;
			end
			if (adv) begin
				if (item_s2.last || item_s2.row_end) begin
					row_q <= '0;
				end else if (item_s2.active) begin
					row_q <= row_new;
				end
				if (item_s2.last) begin
					best_q <= '0;
					best_v_q <= 1'b0;
				end else begin
					best_q <= best_next;
					best_v_q <= best_v_next;
				end
			end
			if (adv && item_s2.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// column store, stage two payload and result payload
	always_ff @(posedge clk) begin
		if (col_write) begin
			col_mem[item_s2.col] <= col_new;
		end
		if (pop) begin
			item_s2 <= head;
			col_rd_s2 <= col_mem[head.col];
			col_vld_s2 <= col_vld_q[head.col];
			fwd_val_s2 <= fwd_val_next;
		end
		if (adv && item_s2.last) begin
			min_cost_q <= best_v_next ? best_next : '0;
			found_q <= best_v_next;
		end
	end

	assign out_valid = out_valid_q;
	assign min_cost = min_cost_q;
	assign found = found_q;

endmodule

@@ rtl/core/grid_window_min_cost.sv @@
// Result path: a last cell passes stage one, the queue and stage two, and its
// result is registered onto out_valid; it waits while the result port stalls.
// Throughput: one cell per cycle while in_stall is low; each cell needs one
// read of the line store and one read-modify-write of the column count store.
// Reset: asynchronous, clears position, counts, column valid bits and the best
// run at once; row history and line store are not cleared and need no pass.
// ----------------------------------------------------------------------------
// grid_window_min_cost: minimum cost window search over a raster grid
// Front stage classifies cells against row and line history, a short queue
// decouples it from the back stage that keeps run counts and the minimum.
// ----------------------------------------------------------------------------
module grid_window_min_cost (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [1:0]                      cell_kind,
	input  logic                            last_cell,
	input  logic                            in_valid,
	output logic                            in_stall,
	output logic [gwmc_pkg::CNT_W-1:0]      min_cost,
	output logic                            found,
	output logic                            out_valid,
	input  logic                            out_stall,
	input  logic                            cfg_we,
	input  logic [gwmc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gwmc_pkg::CFG_W-1:0]      cfg_data
);

	logic                    push;
	logic                    pop;
	logic                    head_valid;
	gwmc_pkg::item_t         push_item;
	gwmc_pkg::item_t         head;
	gwmc_pkg::queue_status_t q_status;

	// intake and classification
	gwmc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cell_kind (cell_kind),
		.last_cell (last_cell),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_status  (q_status),
		.push      (push),
		.push_item (push_item)
	);

	// decoupling queue
	gwmc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid),
		.status     (q_status)
	);

	// run counts and result
	gwmc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.min_cost   (min_cost),
		.found      (found),
		.out_valid  (out_valid),
		.out_stall  (out_stall)
	);

	// queue never takes a transfer while full unless one leaves
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push && (q_status.count == gwmc_pkg::QCNT_FULL)) |-> pop)
		else $error("queue overflow");

	// back stage never pops an empty queue
	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (q_status.count != '0))
		else $error("queue underflow");

	// a full queue holds off intake
	a_full_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(q_status.count == gwmc_pkg::QCNT_FULL) |-> in_stall)
		else $error("intake open while queue full");

endmodule
